// ----- rtl/ctr_pkg.sv -----
package ctr_pkg;

  localparam int DATA_W        = 32;
  localparam int AMP_W         = 15;
  localparam int SAMP_W        = 16;
  localparam int FRAC_BITS     = 30;
  localparam int RENORM_PERIOD = 1024;
  localparam int CNT_W         = $clog2(RENORM_PERIOD);
  localparam int PROD_W        = 2 * DATA_W;
  localparam int ACC_W         = PROD_W + 2;
  localparam int CFG_IDX_W     = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROT_COS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_SIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AMP     = 2'd2;

  localparam logic signed [DATA_W-1:0] UNIT_RE   = DATA_W'(1) << FRAC_BITS;
  localparam logic signed [DATA_W-1:0] COS_RESET = DATA_W'(1) << FRAC_BITS;
  localparam logic signed [DATA_W-1:0] SIN_RESET = '0;
  localparam logic [AMP_W-1:0]         AMP_RESET = AMP_W'(22936);

  localparam int PC_W = 5;
  localparam logic [PC_W-1:0] STEP_START  = PC_W'(0);
  localparam logic [PC_W-1:0] STEP_RENORM = PC_W'(8);
  localparam logic [PC_W-1:0] STEP_FIN    = PC_W'(16);

  typedef enum logic [1:0] {
    A_RE,
    A_IM,
    A_AMP
  } a_sel_t;

  typedef enum logic [2:0] {
    B_RE,
    B_IM,
    B_COS,
    B_SIN,
    B_K
  } b_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_SI,
    WR_SQ,
    WR_TRE,
    WR_COMMIT,
    WR_K
  } wr_op_t;

  typedef enum logic [1:0] {
    J_NEXT,
    J_WRAP,
    J_FIN
  } jmp_t;

  typedef struct packed {
    a_sel_t          mul_a;
    b_sel_t          mul_b;
    acc_op_t         acc_op;
    wr_op_t          wr_op;
    jmp_t            jmp;
    logic [PC_W-1:0] target;
  } ctl_t;

  localparam ctl_t CTL_IDLE = '{A_RE, B_RE, ACC_HOLD, WR_NONE, J_FIN, STEP_START};

  function automatic ctl_t cw(a_sel_t a, b_sel_t b, acc_op_t acc, wr_op_t wr,
                              jmp_t j, logic [PC_W-1:0] tgt);
    ctl_t c;
    c.mul_a  = a;
    c.mul_b  = b;
    c.acc_op = acc;
    c.wr_op  = wr;
    c.jmp    = j;
    c.target = tgt;
    return c;
  endfunction

  // Microprogram. The multiplier product is registered, so each step accumulates the product formed by the step before.
  function automatic ctl_t ucode(logic [PC_W-1:0] pc);
    ctl_t c;
    unique case (pc)
      // sample outputs, then rotation
      PC_W'(0):  c = cw(A_AMP, B_IM,  ACC_HOLD, WR_NONE,   J_NEXT, STEP_START);
      PC_W'(1):  c = cw(A_AMP, B_RE,  ACC_LOAD, WR_NONE,   J_NEXT, STEP_START);
      PC_W'(2):  c = cw(A_RE,  B_COS, ACC_LOAD, WR_SI,     J_NEXT, STEP_START);
      PC_W'(3):  c = cw(A_IM,  B_SIN, ACC_LOAD, WR_SQ,     J_NEXT, STEP_START);
      PC_W'(4):  c = cw(A_RE,  B_SIN, ACC_SUB,  WR_NONE,   J_NEXT, STEP_START);
      PC_W'(5):  c = cw(A_IM,  B_COS, ACC_LOAD, WR_TRE,    J_NEXT, STEP_START);
      PC_W'(6):  c = cw(A_RE,  B_RE,  ACC_ADD,  WR_NONE,   J_NEXT, STEP_START);
      PC_W'(7):  c = cw(A_RE,  B_RE,  ACC_HOLD, WR_COMMIT, J_WRAP, STEP_FIN);
      // renormalization: k = 1.5 - 0.5*|u|^2, u *= k
      PC_W'(8):  c = cw(A_RE,  B_RE,  ACC_HOLD, WR_NONE,   J_NEXT, STEP_START);
      PC_W'(9):  c = cw(A_IM,  B_IM,  ACC_LOAD, WR_NONE,   J_NEXT, STEP_START);
      PC_W'(10): c = cw(A_RE,  B_RE,  ACC_ADD,  WR_NONE,   J_NEXT, STEP_START);
      PC_W'(11): c = cw(A_RE,  B_RE,  ACC_HOLD, WR_K,      J_NEXT, STEP_START);
      PC_W'(12): c = cw(A_RE,  B_K,   ACC_HOLD, WR_NONE,   J_NEXT, STEP_START);
      PC_W'(13): c = cw(A_IM,  B_K,   ACC_LOAD, WR_NONE,   J_NEXT, STEP_START);
      PC_W'(14): c = cw(A_RE,  B_RE,  ACC_LOAD, WR_TRE,    J_NEXT, STEP_START);
      PC_W'(15): c = cw(A_RE,  B_RE,  ACC_HOLD, WR_COMMIT, J_NEXT, STEP_START);
      PC_W'(16): c = cw(A_RE,  B_RE,  ACC_HOLD, WR_NONE,   J_FIN,  STEP_START);
      default:   c = CTL_IDLE;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/complex_tone_rotator.sv -----
// Recursive complex tone generator on one shared 32x32 multiplier.
// Result registered when the final microprogram step retires; a beat that ends
// a renormalization period also runs the renorm steps (one Newton step).
// One beat at a time (in_stall while busy), the final step waiting out out_stall;
// pacing set by the microprogram length, one multiply per step on the multiplier.
// Reset (rst_n low, synchronous): phasor 1+0j, counter 0, registers to defaults.
module complex_tone_rotator (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [ctr_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ctr_pkg::DATA_W-1:0]            cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_restart,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [ctr_pkg::SAMP_W-1:0]     out_i_sample,
  output logic signed [ctr_pkg::SAMP_W-1:0]     out_q_sample
);

  logic signed [ctr_pkg::DATA_W-1:0]  cos_r, sin_r;
  logic        [ctr_pkg::AMP_W-1:0]   amp_r;
  logic                               out_valid_r;
  logic signed [ctr_pkg::SAMP_W-1:0]  out_i_r, out_q_r;
  logic signed [ctr_pkg::SAMP_W-1:0]  si, sq;
  logic                               busy, done, start, out_blocked;
  ctr_pkg::ctl_t                      ctl;

  assign start       = in_valid && !busy;
  assign in_stall    = busy;
  assign out_blocked = out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r <= ctr_pkg::COS_RESET;
      sin_r <= ctr_pkg::SIN_RESET;
      amp_r <= ctr_pkg::AMP_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ctr_pkg::REG_ROT_COS: cos_r <= cfg_data;
        ctr_pkg::REG_ROT_SIN: sin_r <= cfg_data;
        ctr_pkg::REG_AMP:     amp_r <= cfg_data[ctr_pkg::AMP_W-1:0];
        default: ;
      endcase
    end
  end

  ctr_sequencer u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .restart     (in_restart),
    .out_blocked (out_blocked),
    .busy        (busy),
    .done        (done),
    .ctl         (ctl)
  );

  ctr_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .load_unit (start && in_restart),
    .rot_cos   (cos_r),
    .rot_sin   (sin_r),
    .amp       (amp_r),
    .si        (si),
    .sq        (sq)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_i_r <= si;
      out_q_r <= sq;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_i_sample = out_i_r;
  assign out_q_sample = out_q_r;

endmodule

// ----- rtl/ctr_sequencer.sv -----
module ctr_sequencer (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            restart,
  input  logic            out_blocked,
  output logic            busy,
  output logic            done,
  output ctr_pkg::ctl_t   ctl
);

  logic                        busy_r, busy_nxt;
  logic [ctr_pkg::PC_W-1:0]    pc_r, pc_nxt;
  logic [ctr_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                        wrap;

  assign ctl  = busy_r ? ctr_pkg::ucode(pc_r) : ctr_pkg::CTL_IDLE;
  assign busy = busy_r;
  assign wrap = (cnt_r == ctr_pkg::CNT_W'(ctr_pkg::RENORM_PERIOD - 1));
  // result register must be free before the last step retires
  assign done = busy_r && (ctl.jmp == ctr_pkg::J_FIN) && !out_blocked;

  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      pc_nxt   = ctr_pkg::STEP_START;
      if (restart) begin
        cnt_nxt = '0;
      end
    end else if (busy_r) begin
      unique case (ctl.jmp)
        ctr_pkg::J_NEXT: begin
          pc_nxt = pc_r + ctr_pkg::PC_W'(1);
        end
        ctr_pkg::J_WRAP: begin
          if (wrap) begin
            cnt_nxt = '0;
            pc_nxt  = ctr_pkg::STEP_RENORM;
          end else begin
            cnt_nxt = cnt_r + ctr_pkg::CNT_W'(1);
            pc_nxt  = ctl.target;
          end
        end
        ctr_pkg::J_FIN: begin
          if (!out_blocked) begin
            busy_nxt = 1'b0;
            pc_nxt   = ctr_pkg::STEP_START;
          end
        end
        default: begin
          busy_nxt = 1'b0;
          pc_nxt   = ctr_pkg::STEP_START;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= ctr_pkg::STEP_START;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  a_idle_pc: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> pc_r == ctr_pkg::STEP_START)
    else $error("sequencer idle with nonzero step");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ctr_pkg::CNT_W'(ctr_pkg::RENORM_PERIOD - 1))
    else $error("renorm counter out of range");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r && pc_r == ctr_pkg::STEP_START)
    else $error("start did not launch program");

  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !busy_r)
    else $error("sequencer still busy after final step");

  a_wrap_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (start && restart) |=> cnt_r == '0)
    else $error("restart did not clear renorm counter");

endmodule

// ----- rtl/ctr_datapath.sv -----
module ctr_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ctr_pkg::ctl_t                       ctl,
  input  logic                                load_unit,
  input  logic signed [ctr_pkg::DATA_W-1:0]   rot_cos,
  input  logic signed [ctr_pkg::DATA_W-1:0]   rot_sin,
  input  logic        [ctr_pkg::AMP_W-1:0]    amp,
  output logic signed [ctr_pkg::SAMP_W-1:0]   si,
  output logic signed [ctr_pkg::SAMP_W-1:0]   sq
);

  localparam int DW = ctr_pkg::DATA_W;
  localparam int AW = ctr_pkg::ACC_W;
  localparam int FB = ctr_pkg::FRAC_BITS;

  localparam logic signed [AW-1:0] RND_HALF   = AW'(1) << (FB - 1);
  localparam logic signed [AW-1:0] R2_RND     = AW'(1) << FB;
  localparam logic signed [AW-1:0] THREE_HALF = AW'(3) << (FB - 1);
  localparam logic signed [AW-1:0] MAX32      = AW'(2147483647);
  localparam logic signed [AW-1:0] MIN32      = -(AW'(2147483647)) - AW'(1);
  localparam logic signed [AW-1:0] MAX16      = AW'(32767);
  localparam logic signed [AW-1:0] MIN16      = -(AW'(32768));

  function automatic logic signed [DW-1:0] sat32(logic signed [AW-1:0] x);
    logic signed [DW-1:0] y;
    if (x > MAX32) begin
      y = MAX32[DW-1:0];
    end else if (x < MIN32) begin
      y = MIN32[DW-1:0];
    end else begin
      y = x[DW-1:0];
    end
    return y;
  endfunction

  function automatic logic signed [ctr_pkg::SAMP_W-1:0] sat16(logic signed [AW-1:0] x);
    logic signed [ctr_pkg::SAMP_W-1:0] y;
    if (x > MAX16) begin
      y = MAX16[ctr_pkg::SAMP_W-1:0];
    end else if (x < MIN16) begin
      y = MIN16[ctr_pkg::SAMP_W-1:0];
    end else begin
      y = x[ctr_pkg::SAMP_W-1:0];
    end
    return y;
  endfunction

  logic signed [DW-1:0]                  re_r, im_r, tre_r, k_r;
  logic signed [ctr_pkg::PROD_W-1:0]     p_r;
  logic signed [AW-1:0]                  acc_r;
  logic signed [ctr_pkg::SAMP_W-1:0]     si_r, sq_r;
  logic signed [DW-1:0]                  op_a, op_b;
  logic signed [AW-1:0]                  p_ext, rnd, half, k_full;

  always_comb begin
    case (ctl.mul_a)
      ctr_pkg::A_IM:  op_a = im_r;
      ctr_pkg::A_AMP: op_a = {{(DW - ctr_pkg::AMP_W){1'b0}}, amp};
      default:        op_a = re_r;
    endcase
    case (ctl.mul_b)
      ctr_pkg::B_IM:  op_b = im_r;
      ctr_pkg::B_COS: op_b = rot_cos;
      ctr_pkg::B_SIN: op_b = rot_sin;
      ctr_pkg::B_K:   op_b = k_r;
      default:        op_b = re_r;
    endcase
  end

  assign p_ext  = AW'(p_r);
  assign rnd    = (acc_r + RND_HALF) >>> FB;
  // |u|^2 is never negative, so the shift is a plain floor
  assign half   = (acc_r + R2_RND) >>> (FB + 1);
  assign k_full = THREE_HALF - half;

  always_ff @(posedge clk) begin
    p_r <= op_a * op_b;
    case (ctl.acc_op)
      ctr_pkg::ACC_LOAD: acc_r <= p_ext;
      ctr_pkg::ACC_ADD:  acc_r <= acc_r + p_ext;
      ctr_pkg::ACC_SUB:  acc_r <= acc_r - p_ext;
      default:           acc_r <= acc_r;
    endcase
    case (ctl.wr_op)
      ctr_pkg::WR_SI:  si_r  <= sat16(rnd);
      ctr_pkg::WR_SQ:  sq_r  <= sat16(rnd);
      ctr_pkg::WR_TRE: tre_r <= sat32(rnd);
      ctr_pkg::WR_K:   k_r   <= sat32(k_full);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      re_r <= ctr_pkg::UNIT_RE;
      im_r <= '0;
    end else if (load_unit) begin
      re_r <= ctr_pkg::UNIT_RE;
      im_r <= '0;
    end else if (ctl.wr_op == ctr_pkg::WR_COMMIT) begin
      re_r <= tre_r;
      im_r <= sat32(rnd);
    end
  end

  assign si = si_r;
  assign sq = sq_r;

endmodule

// ----- verif/complex_tone_rotator_tb.sv -----
`timescale 1ns / 1ps

typedef logic signed [ctr_pkg::SAMP_W-1:0] sample_t;

typedef struct packed {
  sample_t i_sample;
  sample_t q_sample;
} iq_beat_t;

class tone_scoreboard;
  longint   rot_cos;
  longint   rot_sin;
  longint   amp;
  longint   ph_re;
  longint   ph_im;
  int unsigned renorm_cnt;
  iq_beat_t expected_iq[$];
  int       errors;

  function new();
    rot_cos    = longint'(ctr_pkg::COS_RESET);
    rot_sin    = longint'(ctr_pkg::SIN_RESET);
    amp        = longint'(ctr_pkg::AMP_RESET);
    ph_re      = longint'(ctr_pkg::UNIT_RE);
    ph_im      = 0;
    renorm_cnt = 0;
    errors     = 0;
  endfunction

  // round half up: add half an lsb, then arithmetic shift (floor)
  static function longint round_shift(longint x, int s);
    return (x + (longint'(1) << (s - 1))) >>> s;
  endfunction

  static function longint clamp(longint x, longint lo, longint hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  static function longint sat32(longint x);
    return clamp(x, -(longint'(1) << 31), (longint'(1) << 31) - 1);
  endfunction

  function sample_t scale_out(longint part);
    return sample_t'(clamp(round_shift(amp * part, ctr_pkg::FRAC_BITS), -32768, 32767));
  endfunction

  function void write_reg(logic [ctr_pkg::CFG_IDX_W-1:0] idx,
                          logic [ctr_pkg::DATA_W-1:0] val);
    case (idx)
      ctr_pkg::REG_ROT_COS: rot_cos = longint'(signed'(val));
      ctr_pkg::REG_ROT_SIN: rot_sin = longint'(signed'(val));
      ctr_pkg::REG_AMP:     amp = longint'(val[ctr_pkg::AMP_W-1:0]);
      default: ;
    endcase
  endfunction

  // one Newton step toward unit magnitude: k = 1.5 - 0.5*|u|^2
  function void renormalize();
    longint unsigned mag2;
    longint unsigned half;
    longint k;
    mag2 = ph_re * ph_re;
    mag2 = mag2 + longint'(ph_im * ph_im);
    half = (mag2 + (64'd1 << ctr_pkg::FRAC_BITS)) >> (ctr_pkg::FRAC_BITS + 1);
    k = sat32((longint'(3) << (ctr_pkg::FRAC_BITS - 1)) - longint'(half));
    ph_re = sat32(round_shift(ph_re * k, ctr_pkg::FRAC_BITS));
    ph_im = sat32(round_shift(ph_im * k, ctr_pkg::FRAC_BITS));
  endfunction

  function void note_input(bit restart);
    iq_beat_t beat;
    longint nr;
    longint ni;
    if (restart) begin
      ph_re      = longint'(ctr_pkg::UNIT_RE);
      ph_im      = 0;
      renorm_cnt = 0;
    end
    beat.i_sample = scale_out(ph_im);
    beat.q_sample = scale_out(ph_re);
    expected_iq.push_back(beat);
    nr = round_shift(ph_re * rot_cos - ph_im * rot_sin, ctr_pkg::FRAC_BITS);
    ni = round_shift(ph_re * rot_sin + ph_im * rot_cos, ctr_pkg::FRAC_BITS);
    ph_re = sat32(nr);
    ph_im = sat32(ni);
    if (renorm_cnt >= ctr_pkg::RENORM_PERIOD - 1) begin
      renorm_cnt = 0;
      renormalize();
    end else begin
      renorm_cnt++;
    end
  endfunction

  function void check_result(sample_t i_got, sample_t q_got);
    iq_beat_t want;
    if (expected_iq.size() == 0) begin
      $error("output beat with nothing expected: i_sample %0d, q_sample %0d", i_got, q_got);
      errors++;
      return;
    end
    want = expected_iq.pop_front();
    if (i_got !== want.i_sample) begin
      $error("i_sample: expected %0d, got %0d", want.i_sample, i_got);
      errors++;
    end
    if (q_got !== want.q_sample) begin
      $error("q_sample: expected %0d, got %0d", want.q_sample, q_got);
      errors++;
    end
  endfunction

  function int pending();
    return expected_iq.size();
  endfunction
endclass

module complex_tone_rotator_tb;

  localparam logic [ctr_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int ONE_Q30 = 1 << ctr_pkg::FRAC_BITS;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_wr_en = 1'b0;
  logic [ctr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ctr_pkg::DATA_W-1:0]    cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          in_restart = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  sample_t                       out_i_sample;
  sample_t                       out_q_sample;

  logic quiet = 1'b0;
  logic hold_req = 1'b0;
  bit   hold_taken = 1'b0;
  int   hold_left = 0;
  int   stall_left = 0;

  tone_scoreboard sb;

  complex_tone_rotator uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_restart   (in_restart),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_i_sample (out_i_sample),
    .out_q_sample (out_q_sample)
  );

  always #5 clk = ~clk;

  // result side: check accepted beats, then pick next cycle's stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_i_sample, out_q_sample);
    end
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 99) == 0) begin
      stall_left = $urandom_range(0, 11);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task send_beat(bit restart);
    if (!quiet && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (in_stall);
    sb.note_input(restart);
  endtask

  // drop valid, wait for every expected beat, then let the block go quiet
  task settle(int tail);
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (tail) @(posedge clk);
  endtask

  task write_reg(logic [ctr_pkg::CFG_IDX_W-1:0] idx, logic [ctr_pkg::DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task apply_tone(int c, int s, int a);
    write_reg(REG_SPARE, $urandom);
    write_reg(ctr_pkg::REG_ROT_COS, c);
    write_reg(ctr_pkg::REG_ROT_SIN, s);
    // junk above the amplitude field must be dropped
    write_reg(ctr_pkg::REG_AMP, {17'($urandom), ctr_pkg::AMP_W'(a)});
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int  c;
    int  s;
    int  a;
    int  count;
    int  restart_pct;
    real theta;

    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset tone: phasor parked at 1+0j
    send_beat(1'b0);
    send_beat(1'b0);
    send_beat(1'b1);
    settle(20);
    // quarter turn per beat at full amplitude
    apply_tone(0, ONE_Q30, 32767);
    send_beat(1'b1);
    repeat (4) send_beat(1'b0);
    settle(20);
    // gain above one: phasor and outputs run into saturation
    apply_tone(ONE_Q30, ONE_Q30, 32767);
    repeat (5) send_beat(1'b0);
    settle(20);
    apply_tone(-ONE_Q30, -ONE_Q30, 0);
    send_beat(1'b1);
    send_beat(1'b0);
    send_beat(1'b0);
    settle(20);
    apply_tone(-ONE_Q30, 0, 1);
    send_beat(1'b0);
    send_beat(1'b1);
    send_beat(1'b0);
    send_beat(1'b0);
    settle(20);
    apply_tone(ONE_Q30, 0, 16384);
    send_beat(1'b1);

    // first 8 phases never restart, so the renormalization step is reached
    for (int p = 0; p < 14; p++) begin
      settle(20);
      if (p < 8 || $urandom_range(0, 2) == 0) begin
        theta = $urandom_range(0, 65535) * 6.283185307179586 / 65536.0;
        c = $rtoi($cos(theta) * 1073741824.0);
        s = $rtoi($sin(theta) * 1073741824.0);
      end else if ($urandom_range(0, 1) == 0) begin
        c = (int'($urandom_range(0, 2)) - 1) * ONE_Q30;
        s = (int'($urandom_range(0, 2)) - 1) * ONE_Q30;
      end else begin
        c = int'(longint'($urandom_range(0, 32'h8000_0000)) - ONE_Q30);
        s = int'(longint'($urandom_range(0, 32'h8000_0000)) - ONE_Q30);
      end
      if ($urandom_range(0, 4) == 0) begin
        a = int'($urandom_range(0, 1)) * 32767;
      end else begin
        a = $urandom_range(0, 32767);
      end
      count       = (p < 8) ? 128 : 16;
      restart_pct = (p < 8) ? 0 : 10;
      apply_tone(c, s, a);
      quiet <= (p == 2);
      if (p == 4) begin
        hold_req <= 1'b1;
      end
      for (int k = 0; k < count; k++) begin
        if (p == 5 && k == count / 2) begin
          settle(0);
        end
        send_beat($urandom_range(0, 99) < restart_pct);
      end
    end
    settle(20);

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/ctr_pkg.sv
rtl/ctr_sequencer.sv
rtl/ctr_datapath.sv
rtl/complex_tone_rotator.sv
verif/complex_tone_rotator_tb.sv
